>>> src/icc_pkg.sv
package icc_pkg;

  // Fixed field widths
  localparam int unsigned OpW   = 2;
  localparam int unsigned AddrW = 20;
  localparam int unsigned DataW = 32;
  localparam int unsigned IdW   = 5;

  localparam int unsigned NumSourcesDef = 32;

  // Word addresses (byte offset >> 2)
  localparam logic [AddrW-1:0] AddrPrioEnd  = 20'h00020;
  localparam logic [AddrW-1:0] AddrPending  = 20'h00400;
  localparam logic [AddrW-1:0] AddrMEnable  = 20'h00800;
  localparam logic [AddrW-1:0] AddrSEnable  = 20'h00820;
  localparam logic [AddrW-1:0] AddrMClaim   = 20'h80001;
  localparam logic [AddrW-1:0] AddrSClaim   = 20'h80401;

  localparam logic [DataW-1:0] PrioValue = 32'd1;

  typedef enum logic [OpW-1:0] {
    OpRead  = 2'd0,
    OpWrite = 2'd1,
    OpLine  = 2'd2
  } icc_op_e;

endpackage

>>> src/icc_req_if.sv
interface icc_req_if import icc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [AddrW-1:0] word_addr;
  logic [DataW-1:0] write_data;
  logic [IdW-1:0]   source_id;

  modport source (output valid, output op, output word_addr, output write_data,
                  output source_id, input ready);
  modport sink (input valid, input op, input word_addr, input write_data,
                input source_id, output ready);
endinterface

interface icc_rsp_if import icc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;
  logic             machine_irq;
  logic             supervisor_irq;

  modport source (output valid, output read_data, output machine_irq,
                  output supervisor_irq, input ready);
  modport sink (input valid, input read_data, input machine_irq,
                input supervisor_irq, output ready);
endinterface

>>> src/icc_prio_enc.sv
module icc_prio_enc import icc_pkg::*; #(
  parameter int unsigned NUM_SOURCES = NumSourcesDef
) (
  input  logic [NUM_SOURCES-1:0] hits_i,
  output logic [IdW-1:0]         id_o
);

  // Lowest nonzero source wins; source 0 never does
  always_comb begin
    id_o = '0;
    for (int i = NUM_SOURCES - 1; i >= 1; i--) begin
      if (hits_i[i]) begin
        id_o = IdW'(i);
      end
    end
  end

endmodule

>>> src/interrupt_controller_claim_complete.sv
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while the result side keeps ready high; a new
// item is taken while the result register empties in the same cycle.
// Reset: pending, enables, claimed marks and both claim IDs clear to zero;
// the result register is empty.
module interrupt_controller_claim_complete import icc_pkg::*; #(
  parameter int unsigned NUM_SOURCES = NumSourcesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  icc_req_if.sink    req_i,
  icc_rsp_if.source  rsp_o
);

  logic [NUM_SOURCES-1:0] pend_q, pend_d;
  logic [NUM_SOURCES-1:0] men_q, men_d;
  logic [NUM_SOURCES-1:0] sen_q, sen_d;
  logic [NUM_SOURCES-1:0] claimed_q, claimed_d;
  logic [IdW-1:0]         mclaim_q, mclaim_d;
  logic [IdW-1:0]         sclaim_q, sclaim_d;
  logic                   rsp_valid_q;
  logic [DataW-1:0]       rd_q, rd_d;
  logic                   mirq_q, sirq_q;
  logic                   accept;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    pend_d    = pend_q;
    men_d     = men_q;
    sen_d     = sen_q;
    claimed_d = claimed_q;
    rd_d      = '0;
    unique case (req_i.op)
      OpRead: begin
        if (req_i.word_addr < AddrPrioEnd) begin
          rd_d = PrioValue;
        end else if (req_i.word_addr == AddrPending) begin
          rd_d = DataW'(pend_q);
        end else if (req_i.word_addr == AddrMEnable) begin
          rd_d = DataW'(men_q);
        end else if (req_i.word_addr == AddrSEnable) begin
          rd_d = DataW'(sen_q);
        end else if (req_i.word_addr == AddrMClaim) begin
          rd_d = DataW'(mclaim_q);
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (mclaim_q == IdW'(i)) claimed_d[i] = 1'b1;
          end
        end else if (req_i.word_addr == AddrSClaim) begin
          rd_d = DataW'(sclaim_q);
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (sclaim_q == IdW'(i)) claimed_d[i] = 1'b1;
          end
        end
      end
      OpWrite: begin
        if (req_i.word_addr == AddrPending) begin
          pend_d = req_i.write_data[NUM_SOURCES-1:0];
        end else if (req_i.word_addr == AddrMEnable) begin
          men_d = req_i.write_data[NUM_SOURCES-1:0];
        end else if (req_i.word_addr == AddrSEnable) begin
          sen_d = req_i.write_data[NUM_SOURCES-1:0];
        end else if (req_i.word_addr == AddrMClaim || req_i.word_addr == AddrSClaim) begin
          // completion: IDs beyond the sources match no bit and drop out
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (req_i.write_data == DataW'(i)) claimed_d[i] = 1'b0;
          end
        end
      end
      OpLine: begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
          if (req_i.source_id == IdW'(i)) begin
            pend_d[i] = req_i.write_data[0] && !claimed_q[i];
          end
        end
      end
      default: ;
    endcase
  end

  icc_prio_enc #(.NUM_SOURCES(NUM_SOURCES)) u_mprio (
    .hits_i (pend_d & men_d),
    .id_o   (mclaim_d)
  );

  icc_prio_enc #(.NUM_SOURCES(NUM_SOURCES)) u_sprio (
    .hits_i (pend_d & sen_d),
    .id_o   (sclaim_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      men_q       <= '0;
      sen_q       <= '0;
      claimed_q   <= '0;
      mclaim_q    <= '0;
      sclaim_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pend_q    <= pend_d;
        men_q     <= men_d;
        sen_q     <= sen_d;
        claimed_q <= claimed_d;
        mclaim_q  <= mclaim_d;
        sclaim_q  <= sclaim_d;
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q   <= rd_d;
      mirq_q <= (mclaim_d != '0);
      sirq_q <= (sclaim_d != '0);
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.read_data      = rd_q;
  assign rsp_o.machine_irq    = mirq_q;
  assign rsp_o.supervisor_irq = sirq_q;

  a_mirq_matches_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (mirq_q == (mclaim_q != '0)))
    else $error("machine irq disagrees with claim ID");

  a_sirq_matches_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (sirq_q == (sclaim_q != '0)))
    else $error("supervisor irq disagrees with claim ID");

  a_mclaim_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mclaim_q != '0) |-> ((((pend_q & men_q) >> mclaim_q) & NUM_SOURCES'(1)) != '0))
    else $error("machine claim ID not enabled and pending");

  a_sclaim_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sclaim_q != '0) |-> ((((pend_q & sen_q) >> sclaim_q) & NUM_SOURCES'(1)) != '0))
    else $error("supervisor claim ID not enabled and pending");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_q |-> req_i.ready)
    else $error("input stalled with empty result register");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench import icc_pkg::*;;

  localparam logic [OpW-1:0]   OpReserved  = 2'd3;
  localparam logic [AddrW-1:0] AddrMThresh = 20'h80000;
  localparam logic [AddrW-1:0] AddrSThresh = 20'h80400;

  localparam int unsigned RandItems  = 450;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned HoldAfter  = 150;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [AddrW-1:0] word_addr;
    logic [DataW-1:0] write_data;
    logic [IdW-1:0]   source_id;
  } icc_req_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             machine_irq;
    logic             supervisor_irq;
  } icc_rsp_t;

  typedef struct packed {
    icc_req_t req;
    logic     known;
    icc_rsp_t rsp;
  } dir_row_t;

  localparam int unsigned DirRows = 26;
  localparam dir_row_t DirTable [DirRows] = '{
    '{'{OpRead,  AddrPending,  32'h0,        5'd0},  1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{OpRead,  20'h00000,    32'h0,        5'd0},  1'b1, '{32'h1, 1'b0, 1'b0}},
    '{'{OpRead,  20'h0001F,    32'h0,        5'd0},  1'b1, '{32'h1, 1'b0, 1'b0}},
    '{'{OpRead,  AddrPrioEnd,  32'h0,        5'd0},  1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{OpRead,  AddrMEnable,  32'h0,        5'd0},  1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{OpRead,  AddrMThresh,  32'h0,        5'd0},  1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{OpRead,  AddrSThresh,  32'h0,        5'd0},  1'b1, '{32'h0, 1'b0, 1'b0}},
    // claim with nothing pending: returns zero and marks source zero claimed
    '{'{OpRead,  AddrMClaim,   32'h0,        5'd0},  1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{OpWrite, AddrMEnable,  32'hFFFFFFFF, 5'd0},  1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{OpWrite, AddrSEnable,  32'hAAAAAAAA, 5'd0},  1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{OpLine,  20'h00000,    32'h1,        5'd0},  1'b0, '0},
    '{'{OpLine,  20'h00000,    32'h1,        5'd31}, 1'b0, '0},
    '{'{OpRead,  AddrMClaim,   32'h0,        5'd0},  1'b0, '0},
    '{'{OpLine,  20'hFFFFF,    32'h1,        5'd1},  1'b0, '0},
    '{'{OpRead,  AddrSClaim,   32'h0,        5'd0},  1'b0, '0},
    '{'{OpLine,  20'h00000,    32'hFFFFFFFE, 5'd1},  1'b0, '0},
    // line high on a claimed source drops its pending bit
    '{'{OpLine,  20'h00000,    32'h1,        5'd31}, 1'b0, '0},
    '{'{OpWrite, AddrMClaim,   32'd32,       5'd0},  1'b0, '0},
    '{'{OpWrite, AddrMClaim,   32'hFFFFFFFF, 5'd0},  1'b0, '0},
    '{'{OpWrite, AddrMClaim,   32'd31,       5'd0},  1'b0, '0},
    '{'{OpWrite, AddrPending,  32'hFFFFFFFF, 5'd0},  1'b0, '0},
    '{'{OpRead,  AddrPending,  32'h0,        5'd0},  1'b0, '0},
    '{'{OpReserved, AddrPending, 32'h0,      5'd0},  1'b0, '0},
    '{'{OpWrite, AddrSClaim,   32'd1,        5'd0},  1'b0, '0},
    '{'{OpRead,  20'hFFFFF,    32'h0,        5'd0},  1'b0, '0},
    '{'{OpWrite, AddrPending,  32'h0,        5'd0},  1'b1, '{32'h0, 1'b0, 1'b0}}
  };

  logic clk_i;
  logic rst_ni;

  icc_req_if req_if ();
  icc_rsp_if rsp_if ();

  interrupt_controller_claim_complete dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow copy of the controller state
  logic [31:0]    pend_r;
  logic [31:0]    men_r;
  logic [31:0]    sen_r;
  logic [31:0]    claimed_r;
  logic [IdW-1:0] mid_r;
  logic [IdW-1:0] sid_r;

  icc_rsp_t    outstanding_rsps [$];
  icc_rsp_t    got_rsp;
  int unsigned bad_count;
  int unsigned items_sent;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [IdW-1:0] lowest_hit(input logic [31:0] en);
    logic [31:0] hits;
    hits = en & pend_r;
    for (int j = 1; j < 32; j++) begin
      if (hits[j]) return IdW'(j);
    end
    return '0;
  endfunction

  function automatic icc_rsp_t plic_next(input icc_req_t it);
    icc_rsp_t r;
    r.read_data = '0;
    case (it.op)
      OpRead: begin
        if (it.word_addr < AddrPrioEnd) begin
          r.read_data = PrioValue;
        end else if (it.word_addr == AddrPending) begin
          r.read_data = pend_r;
        end else if (it.word_addr == AddrMEnable) begin
          r.read_data = men_r;
        end else if (it.word_addr == AddrSEnable) begin
          r.read_data = sen_r;
        end else if (it.word_addr == AddrMClaim) begin
          claimed_r[mid_r] = 1'b1;
          r.read_data = DataW'(mid_r);
        end else if (it.word_addr == AddrSClaim) begin
          claimed_r[sid_r] = 1'b1;
          r.read_data = DataW'(sid_r);
        end
      end
      OpWrite: begin
        if (it.word_addr == AddrPending) begin
          pend_r = it.write_data;
        end else if (it.word_addr == AddrMEnable) begin
          men_r = it.write_data;
        end else if (it.word_addr == AddrSEnable) begin
          sen_r = it.write_data;
        end else if (it.word_addr == AddrMClaim || it.word_addr == AddrSClaim) begin
          // completions of nonexistent IDs are dropped
          if (it.write_data < 32) claimed_r[it.write_data[4:0]] = 1'b0;
        end
      end
      OpLine: begin
        if (it.write_data[0] && !claimed_r[it.source_id]) begin
          pend_r[it.source_id] = 1'b1;
        end else begin
          pend_r[it.source_id] = 1'b0;
        end
      end
      default: ;
    endcase
    mid_r = lowest_hit(men_r);
    sid_r = lowest_hit(sen_r);
    r.machine_irq    = (mid_r != '0);
    r.supervisor_irq = (sid_r != '0);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic flag_bad(input string msg);
    bad_count++;
    if (bad_count <= MaxReports) $display("mismatch: %s", msg);
  endtask

  task automatic send_item(input icc_req_t it, input logic known, input icc_rsp_t typed_rsp);
    int unsigned gap;
    icc_rsp_t    want;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= it.op;
    req_if.word_addr  <= it.word_addr;
    req_if.write_data <= it.write_data;
    req_if.source_id  <= it.source_id;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    want = plic_next(it);
    outstanding_rsps.push_back(known ? typed_rsp : want);
    items_sent++;
  endtask

  initial begin
    icc_req_t    it;
    dir_row_t    row;
    int unsigned sel;
    int unsigned k;
    pend_r      = '0;
    men_r       = '0;
    sen_r       = '0;
    claimed_r   = '0;
    mid_r       = '0;
    sid_r       = '0;
    bad_count   = 0;
    items_sent  = 0;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.op         <= '0;
    req_if.word_addr  <= '0;
    req_if.write_data <= '0;
    req_if.source_id  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      row = DirTable[i];
      send_item(row.req, row.known, row.rsp);
    end

    for (int i = 0; i < RandItems; i++) begin
      sel           = $urandom_range(0, 19);
      it.source_id  = IdW'($urandom_range(0, 31));
      it.write_data = $urandom;
      it.word_addr  = AddrW'($urandom);
      if (sel < 8) begin
        it.op = OpLine;
        if ($urandom_range(0, 9) < 7) it.write_data[0] = 1'b1;
      end else begin
        it.op = (sel < 14) ? OpRead : (sel < 19) ? OpWrite : OpReserved;
        case ($urandom_range(0, 15))
          0, 1:      it.word_addr = AddrPending;
          2, 3:      it.word_addr = AddrMEnable;
          4, 5:      it.word_addr = AddrSEnable;
          6, 7, 14:  it.word_addr = AddrMClaim;
          8, 9, 15:  it.word_addr = AddrSClaim;
          10:        it.word_addr = AddrW'($urandom_range(0, 32));
          11:        it.word_addr = $urandom_range(0, 1) ? AddrMThresh : AddrSThresh;
          12: begin
            case ($urandom_range(0, 4))
              0:       it.word_addr = AddrW'(AddrPending - 1);
              1:       it.word_addr = AddrW'(AddrPending + 1);
              2:       it.word_addr = AddrW'(AddrMEnable + 1);
              3:       it.word_addr = AddrW'(AddrSEnable - 1);
              default: it.word_addr = AddrW'(AddrSClaim + 1);
            endcase
          end
          default: ;
        endcase
        if (it.op == OpWrite) begin
          k = $urandom_range(0, 99);
          if (it.word_addr == AddrMClaim || it.word_addr == AddrSClaim) begin
            // mostly complete a source that is really claimed
            if (k < 60 && claimed_r != '0) begin
              k = $urandom_range(0, 31);
              while (!claimed_r[k[4:0]]) k = (k + 1) % 32;
              it.write_data = DataW'(k);
            end else if (k < 85) begin
              it.write_data = DataW'($urandom_range(0, 40));
            end
          end else if (k < 25) begin
            it.write_data = '1;
          end else if (k < 35) begin
            it.write_data = '0;
          end
        end
      end
      send_item(it, 1'b0, '0);
    end

    req_if.valid <= 1'b0;
    while (outstanding_rsps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (bad_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off to back up the input
  initial begin
    int unsigned run;
    bit          hold_done;
    hold_done = 1'b0;
    forever begin
      if (!hold_done && items_sent >= HoldAfter) begin
        hold_done = 1'b1;
        run = HoldCycles;
        rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        run = pick_gap() + 1;
        rsp_if.ready <= 1'b0;
      end else begin
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
        rsp_if.ready <= 1'b1;
      end
      repeat (run) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (outstanding_rsps.size() == 0) begin
        flag_bad($sformatf("result with no item: read_data %h m %b s %b",
                           rsp_if.read_data, rsp_if.machine_irq, rsp_if.supervisor_irq));
      end else begin
        got_rsp = outstanding_rsps.pop_front();
        if (rsp_if.read_data !== got_rsp.read_data ||
            rsp_if.machine_irq !== got_rsp.machine_irq ||
            rsp_if.supervisor_irq !== got_rsp.supervisor_irq) begin
          flag_bad($sformatf("exp read_data %h m %b s %b, got read_data %h m %b s %b",
                             got_rsp.read_data, got_rsp.machine_irq, got_rsp.supervisor_irq,
                             rsp_if.read_data, rsp_if.machine_irq, rsp_if.supervisor_irq));
        end
      end
    end
  end

  // abort when neither side moves an item for too long
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial idle_cycles = 0;

endmodule
